### hw/rtl/brf_pkg.sv
`default_nettype none

package brf_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 64;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int AMT_W   = 7;
  localparam int LEVEL_W = 9;
  localparam int CAP_W   = 9;

  localparam logic [CAP_W-1:0]  CAP_RESET = 9'd256;
  localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_PEEK  = 2'd2,
    FN_GRAB  = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [BYTE_W-1:0]  wbyte;
    logic [AMT_W-1:0]   amt;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/brf_ifs.sv
`default_nettype none

interface brf_in_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::FUNC_W-1:0]  func;
  logic [brf_pkg::BYTE_W-1:0]  write_byte;
  logic [brf_pkg::AMT_W-1:0]   amount;
  modport source (output valid, func, write_byte, amount, input ready);
  modport sink   (input valid, func, write_byte, amount, output ready);
endinterface

interface brf_out_if;
  logic                         valid;
  logic                         ready;
  logic [brf_pkg::BYTE_W-1:0]   out_byte;
  logic                         byte_valid;
  logic                         last;
  logic [brf_pkg::AMT_W-1:0]    moved;
  logic [brf_pkg::LEVEL_W-1:0]  level;
  modport source (output valid, out_byte, byte_valid, last, moved, level, input ready);
  modport sink   (input valid, out_byte, byte_valid, last, moved, level, output ready);
endinterface

interface brf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::CAP_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/brf_front.sv
`default_nettype none

module brf_front #(
  parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  brf_in_if.sink             in_ch,
  output brf_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);

  localparam logic [brf_pkg::AMT_W-1:0] BURST = brf_pkg::AMT_W'(MAX_BURST);

  logic          valid_r;
  brf_pkg::cmd_t cmd_r;
  brf_pkg::cmd_t cmd_nxt;

  assign in_ch.ready = !valid_r || cmd_ready;
  assign cmd_valid   = valid_r;
  assign cmd         = cmd_r;

  // Amounts beyond the burst limit are clipped here so the back end never sees them.
  always_comb begin
    cmd_nxt.func  = brf_pkg::func_t'(in_ch.func);
    cmd_nxt.wbyte = in_ch.write_byte;
    cmd_nxt.amt   = (in_ch.amount > BURST) ? BURST : in_ch.amount;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (cmd_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/brf_cmdq.sv
`default_nettype none

module brf_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire brf_pkg::cmd_t  push_cmd,
  input  wire logic           push_valid,
  output logic                push_ready,
  output brf_pkg::cmd_t       pop_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready
);

  localparam int CNT_W = brf_pkg::Q_AW + 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(brf_pkg::Q_DEPTH);

  brf_pkg::cmd_t             entry_r [brf_pkg::Q_DEPTH];
  logic [brf_pkg::Q_AW-1:0]  wr_ptr_r;
  logic [brf_pkg::Q_AW-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]          count_r;
  logic                      do_push;
  logic                      do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/brf_back.sv
`default_nettype none

module brf_back #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire brf_pkg::cmd_t               cmd,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire logic                        cfg_we,
  input  wire logic [brf_pkg::CAP_W-1:0]   cfg_data,
  brf_out_if.source                        out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int LW = (FW > brf_pkg::AMT_W) ? FW : brf_pkg::AMT_W;
  localparam int AMW = brf_pkg::AMT_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT, S_NOHIT} state_t;

  function automatic logic [FW-1:0] eff_cap(input logic [brf_pkg::CAP_W-1:0] v);
    logic [FW-1:0] r;
    if (v == '0) begin
      r = FW'(1);
    end else if (32'(v) > 32'(DEPTH)) begin
      r = FW'(DEPTH);
    end else begin
      r = FW'(v);
    end
    return r;
  endfunction

  state_t                      state_r;
  logic [AW-1:0]               head_r;
  logic [AW-1:0]               tail_r;
  logic [AW-1:0]               rd_ptr_r;
  logic [FW-1:0]               fill_r;
  logic [FW-1:0]               cap_r;
  logic [AMW-1:0]              remain_r;
  logic [AMW-1:0]              lim_r;
  logic [AMW-1:0]              chk_idx_r;
  logic [AMW-1:0]              moved_r;
  logic                        dv_r;
  logic                        rlast_r;
  logic                        pop_r;
  logic [brf_pkg::BYTE_W-1:0]  rdata_r;

  logic                        out_v_r;
  logic [brf_pkg::BYTE_W-1:0]  out_byte_r;
  logic                        out_bv_r;
  logic                        out_last_r;
  logic [AMW-1:0]              out_moved_r;
  logic [brf_pkg::LEVEL_W-1:0] out_level_r;

  logic [brf_pkg::BYTE_W-1:0]  mem [DEPTH];

  logic                        out_free;
  logic                        take;
  logic                        fill_lt_cap;
  logic [FW-1:0]               fill_inc;
  logic [AMW-1:0]              span;
  logic                        emit_load;
  logic                        mem_re;
  logic                        mem_we;
  logic [AMW-1:0]              hit_n;

  function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p, input logic [FW-1:0] c);
    logic [FW-1:0] p1;
    p1 = FW'(p) + FW'(1);
    return (p1 >= c) ? '0 : AW'(p1);
  endfunction

  assign out_free    = !out_v_r || out_ch.ready;
  assign take        = (state_r == S_IDLE) && cmd_valid && out_free;
  assign cmd_ready   = (state_r == S_IDLE) && out_free;
  assign fill_lt_cap = (fill_r < cap_r);
  assign fill_inc    = fill_r + FW'(1);
  // The bytes in reach: the requested amount, but never more than are stored.
  assign span        = (LW'(fill_r) < LW'(cmd.amt)) ? AMW'(fill_r) : cmd.amt;
  assign emit_load   = (state_r == S_EMIT) && dv_r && out_free;
  assign hit_n       = chk_idx_r + AMW'(1);
  assign mem_we      = take && (cmd.func == brf_pkg::FN_WRITE) && fill_lt_cap;

  always_comb begin
    mem_re = 1'b0;
    unique case (state_r)
      S_SCAN:  mem_re = (remain_r != '0);
      S_EMIT:  mem_re = (remain_r != '0) && (!dv_r || emit_load);
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= cmd.wbyte;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = out_bv_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.moved      = out_moved_r;
  assign out_ch.level      = out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      cap_r   <= eff_cap(brf_pkg::CAP_RESET);
      out_v_r <= 1'b0;
      dv_r    <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            unique case (cmd.func) inside
              brf_pkg::FN_WRITE: begin
                out_v_r     <= 1'b1;
                out_byte_r  <= '0;
                out_bv_r    <= 1'b0;
                out_last_r  <= 1'b1;
                if (fill_lt_cap) begin
                  tail_r      <= step_ptr(tail_r, cap_r);
                  fill_r      <= fill_inc;
                  out_moved_r <= AMW'(1);
                  out_level_r <= brf_pkg::LEVEL_W'(fill_inc);
                end else begin
                  out_moved_r <= '0;
                  out_level_r <= brf_pkg::LEVEL_W'(fill_r);
                end
              end
              brf_pkg::FN_READ, brf_pkg::FN_PEEK: begin
                if (span == '0) begin
                  out_v_r     <= 1'b1;
                  out_byte_r  <= '0;
                  out_bv_r    <= 1'b0;
                  out_last_r  <= 1'b1;
                  out_moved_r <= '0;
                  out_level_r <= brf_pkg::LEVEL_W'(fill_r);
                end else begin
                  remain_r <= span;
                  moved_r  <= span;
                  rd_ptr_r <= head_r;
                  dv_r     <= 1'b0;
                  pop_r    <= (cmd.func == brf_pkg::FN_READ);
                  if (cmd.func == brf_pkg::FN_READ) begin
                    fill_r <= fill_r - FW'(span);
                  end
                  state_r  <= S_EMIT;
                end
              end
              brf_pkg::FN_GRAB: begin
                if (span == '0) begin
                  out_v_r     <= 1'b1;
                  out_byte_r  <= '0;
                  out_bv_r    <= 1'b0;
                  out_last_r  <= 1'b1;
                  out_moved_r <= '0;
                  out_level_r <= brf_pkg::LEVEL_W'(fill_r);
                end else begin
                  remain_r  <= span;
                  lim_r     <= span;
                  chk_idx_r <= '0;
                  rd_ptr_r  <= head_r;
                  dv_r      <= 1'b0;
                  state_r   <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end

        // One stored byte is fetched per cycle and checked in the cycle after its fetch.
        S_SCAN: begin
          if (mem_re) begin
            rd_ptr_r <= step_ptr(rd_ptr_r, cap_r);
            remain_r <= remain_r - AMW'(1);
          end
          dv_r <= mem_re;
          if (dv_r) begin
            if (rdata_r == brf_pkg::NEWLINE) begin
              // The line fits: drop the fetch in flight and replay from the head.
              remain_r <= hit_n;
              moved_r  <= hit_n;
              rd_ptr_r <= head_r;
              fill_r   <= fill_r - FW'(hit_n);
              pop_r    <= 1'b1;
              dv_r     <= 1'b0;
              state_r  <= S_EMIT;
            end else begin
              chk_idx_r <= hit_n;
              if (hit_n == lim_r) begin
                dv_r    <= 1'b0;
                state_r <= S_NOHIT;
              end
            end
          end
        end

        S_EMIT: begin
          if (emit_load) begin
            out_v_r     <= 1'b1;
            out_byte_r  <= rdata_r;
            out_bv_r    <= 1'b1;
            out_last_r  <= rlast_r;
            out_moved_r <= moved_r;
            out_level_r <= brf_pkg::LEVEL_W'(fill_r);
          end
          if (mem_re) begin
            rd_ptr_r <= step_ptr(rd_ptr_r, cap_r);
            remain_r <= remain_r - AMW'(1);
            rlast_r  <= (remain_r == AMW'(1));
            dv_r     <= 1'b1;
          end else if (emit_load) begin
            dv_r <= 1'b0;
          end
          if (emit_load && rlast_r) begin
            // The read pointer already sits one past the final byte.
            if (pop_r) begin
              head_r <= rd_ptr_r;
            end
            state_r <= S_IDLE;
          end
        end

        S_NOHIT: begin
          if (out_free) begin
            out_v_r     <= 1'b1;
            out_byte_r  <= '0;
            out_bv_r    <= 1'b0;
            out_last_r  <= 1'b1;
            out_moved_r <= '0;
            out_level_r <= brf_pkg::LEVEL_W'(fill_r);
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      // A capacity write empties the ring.
      if (cfg_we) begin
        cap_r  <= eff_cap(cfg_data);
        head_r <= '0;
        tail_r <= '0;
        fill_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/byte_ring_fifo_with_line_grab.sv
// Channel  | Dir | Handshake          | Payload
// in_ch    | in  | valid / ready      | func, write_byte, amount
// out_ch   | out | valid / ready      | out_byte, byte_valid, last, moved, level
// cfg_ch   | in  | valid / ready (=1) | data: capacity
//
// A write is handled in the back end on its own. A read or peek of n bytes fetches
// them one by one, and a line grab first scans up to min(amount, level) bytes for
// a newline, then delivers the line; the single read port of the byte store sets this.
// The command queue lets the front take new items while the back end is busy.
// Reset is synchronous and leaves the byte store untouched; stored bytes are
// only read after they have been written. A stalled output holds the back end.
`default_nettype none

module byte_ring_fifo_with_line_grab #(
  parameter int DEPTH     = brf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  brf_in_if.sink     in_ch,
  brf_out_if.source  out_ch,
  brf_cfg_if.sink    cfg_ch
);

  brf_pkg::cmd_t front_cmd;
  logic          front_valid;
  logic          front_ready;
  brf_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_ready;

  assign cfg_ch.ready = 1'b1;

  brf_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  brf_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (q_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cfg_we    (cfg_ch.valid && cfg_ch.ready),
    .cfg_data  (cfg_ch.data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### hw/rtl/brf_checker.sv
`default_nettype none

module brf_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [brf_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                         byte_valid,
  input wire logic                         last,
  input wire logic [brf_pkg::AMT_W-1:0]    moved,
  input wire logic [brf_pkg::LEVEL_W-1:0]  level
);

  // Items taken whose final result has not yet been delivered.
  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_valid && in_ready) - 4'(out_valid && out_ready && last);
    end
  end

  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_byte, byte_valid, last, moved, level}))
    else $error("stalled result changed");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without an outstanding item");

  a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> last && out_byte == '0)
    else $error("empty result not final or carries data");

  a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_valid |-> moved != '0)
    else $error("byte delivered with zero moved count");

endmodule

bind byte_ring_fifo_with_line_grab brf_checker u_brf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .last       (out_ch.last),
  .moved      (out_ch.moved),
  .level      (out_ch.level)
);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [brf_pkg::BYTE_W-1:0]  data;
    logic                        has_byte;
    logic                        last;
    logic [brf_pkg::AMT_W-1:0]   moved;
    logic [brf_pkg::LEVEL_W-1:0] level;
  } fifo_result_t;

  logic clk;
  logic rst_n;

  brf_in_if  in_if ();
  brf_out_if out_if ();
  brf_cfg_if cfg_if ();

  byte_ring_fifo_with_line_grab u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow copy of the ring, its pointers and the capacity register.
  logic [brf_pkg::BYTE_W-1:0] ring_mem [brf_pkg::DEPTH_DEF];
  int unsigned                rd_ptr;
  int unsigned                wr_ptr;
  int unsigned                stored;
  logic [brf_pkg::CAP_W-1:0]  ring_cap;

  fifo_result_t owed_results [$];

  int unsigned items_sent;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned caps_used;
  bit          src_idle;
  bit          sink_idle;
  int unsigned sink_gap     = 0;
  int unsigned hold_left;
  event        hold_go;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic void owe_result(input logic [brf_pkg::BYTE_W-1:0] data,
                                     input logic has_byte, input logic last,
                                     input int unsigned moved);
    fifo_result_t r;
    r.data     = data;
    r.has_byte = has_byte;
    r.last     = last;
    r.moved    = moved[brf_pkg::AMT_W-1:0];
    r.level    = stored[brf_pkg::LEVEL_W-1:0];
    owed_results.push_back(r);
  endfunction

  task automatic apply_fifo_cmd(input brf_pkg::func_t f, input logic [brf_pkg::BYTE_W-1:0] wb,
                                input logic [brf_pkg::AMT_W-1:0] amt_in);
    int unsigned cap;
    int unsigned amt;
    int unsigned n;
    int unsigned scan;
    int unsigned pos;
    bit          seen_nl;
    cap = (ring_cap == 0) ? 1 :
          ((ring_cap > brf_pkg::DEPTH_DEF) ? brf_pkg::DEPTH_DEF : ring_cap);
    amt = (amt_in > brf_pkg::MAX_BURST_DEF) ? brf_pkg::MAX_BURST_DEF : amt_in;
    n   = 0;
    if (f == brf_pkg::FN_WRITE) begin
      if (stored < cap) begin
        ring_mem[wr_ptr] = wb;
        wr_ptr = (wr_ptr + 1) % cap;
        stored++;
        n = 1;
      end
      owe_result('0, 1'b0, 1'b1, n);
      return;
    end
    if (f == brf_pkg::FN_GRAB) begin
      // The whole line, newline included, must fit in the amount or nothing moves.
      seen_nl = 1'b0;
      pos     = rd_ptr;
      for (scan = 0; scan < stored; scan++) begin
        if (ring_mem[pos] == brf_pkg::NEWLINE) begin
          seen_nl = 1'b1;
          break;
        end
        pos = (pos + 1) % cap;
      end
      if (seen_nl && scan + 1 <= amt) n = scan + 1;
    end else begin
      n = (amt < stored) ? amt : stored;
    end
    if (n == 0) begin
      owe_result('0, 1'b0, 1'b1, 0);
      return;
    end
    pos = rd_ptr;
    if (f != brf_pkg::FN_PEEK) begin
      rd_ptr = (rd_ptr + n) % cap;
      stored -= n;
    end
    for (scan = 0; scan < n; scan++) begin
      owe_result(ring_mem[pos], 1'b1, scan + 1 == n, n);
      pos = (pos + 1) % cap;
    end
  endtask

  task automatic send_cmd(input brf_pkg::func_t f, input logic [brf_pkg::BYTE_W-1:0] wb,
                          input logic [brf_pkg::AMT_W-1:0] amt);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= f;
    in_if.write_byte <= wb;
    in_if.amount     <= amt;
    do @(posedge clk); while (!in_if.ready);
    apply_fifo_cmd(f, wb, amt);
    items_sent++;
  endtask

  task automatic park_input();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [brf_pkg::CAP_W-1:0] value);
    park_input();
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    ring_cap = value;
    rd_ptr   = 0;
    wr_ptr   = 0;
    stored   = 0;
    caps_used++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed_commands();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_cmd(brf_pkg::FN_READ, 8'h00, 7'd5);
    send_cmd(brf_pkg::FN_GRAB, 8'h00, 7'd64);
    send_cmd(brf_pkg::FN_WRITE, 8'h00, 7'd0);
    send_cmd(brf_pkg::FN_WRITE, 8'hFF, 7'd127);
    send_cmd(brf_pkg::FN_WRITE, 8'h41, 7'd0);
    send_cmd(brf_pkg::FN_WRITE, brf_pkg::NEWLINE, 7'd0);
    send_cmd(brf_pkg::FN_WRITE, 8'h55, 7'd0);
    send_cmd(brf_pkg::FN_WRITE, 8'hAA, 7'd0);
    send_cmd(brf_pkg::FN_PEEK, 8'h00, 7'd0);
    send_cmd(brf_pkg::FN_PEEK, 8'h00, 7'd127);
    send_cmd(brf_pkg::FN_GRAB, 8'h00, 7'd3);
    send_cmd(brf_pkg::FN_GRAB, 8'h00, 7'd4);
    send_cmd(brf_pkg::FN_GRAB, 8'h00, 7'd64);
    send_cmd(brf_pkg::FN_READ, 8'h00, 7'd1);
    send_cmd(brf_pkg::FN_READ, 8'h00, 7'd64);
    send_cmd(brf_pkg::FN_READ, 8'h00, 7'd0);
  endtask

  task automatic test_capacity_corners();
    // A capacity of zero behaves as one slot, so the second write is dropped.
    write_capacity(9'd0);
    send_cmd(brf_pkg::FN_WRITE, 8'h12, 7'd0);
    send_cmd(brf_pkg::FN_WRITE, 8'h34, 7'd0);
    send_cmd(brf_pkg::FN_READ, 8'h00, 7'd2);
    // With three slots the line below straddles the end of the ring.
    write_capacity(9'd3);
    send_cmd(brf_pkg::FN_WRITE, 8'h61, 7'd0);
    send_cmd(brf_pkg::FN_WRITE, 8'h62, 7'd0);
    send_cmd(brf_pkg::FN_READ, 8'h00, 7'd2);
    send_cmd(brf_pkg::FN_WRITE, 8'h63, 7'd0);
    send_cmd(brf_pkg::FN_WRITE, brf_pkg::NEWLINE, 7'd0);
    send_cmd(brf_pkg::FN_GRAB, 8'h00, 7'd2);
  endtask

  task automatic test_stall_and_drain();
    int unsigned                k;
    logic [brf_pkg::BYTE_W-1:0] wb;
    write_capacity(9'd64);
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    @(posedge clk);
    -> hold_go;
    for (k = 0; k < 24; k++) begin
      wb = (k % 5 == 4) ? brf_pkg::NEWLINE : 8'($urandom_range(0, 255));
      send_cmd(brf_pkg::FN_WRITE, wb, 7'd0);
    end
    for (k = 0; k < 4; k++) send_cmd(brf_pkg::FN_PEEK, 8'h00, 7'd8);
    // Sender stops until every owed result has been seen.
    park_input();
    wait_drained();
    src_idle = 1'b1;
    for (k = 0; k < 4; k++) send_cmd(brf_pkg::FN_GRAB, 8'h00, 7'd10);
    send_cmd(brf_pkg::FN_READ, 8'h00, 7'd127);
  endtask

  task automatic test_random_traffic(input logic [brf_pkg::CAP_W-1:0] cap_val,
                                     input int unsigned count);
    int unsigned                k;
    int unsigned                pick;
    int unsigned                mode;
    brf_pkg::func_t             f;
    logic [brf_pkg::BYTE_W-1:0] wb;
    logic [brf_pkg::AMT_W-1:0]  amt;
    write_capacity(cap_val);
    mode      = $urandom_range(0, 3);
    src_idle  = mode[0];
    sink_idle = mode[1];
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) wb = brf_pkg::NEWLINE;
      else wb = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) amt = 7'($urandom_range(0, 127));
      else amt = 7'($urandom_range(0, 12));
      if (pick < 50) f = brf_pkg::FN_WRITE;
      else if (pick < 65) f = brf_pkg::FN_READ;
      else if (pick < 75) f = brf_pkg::FN_PEEK;
      else f = brf_pkg::FN_GRAB;
      send_cmd(f, wb, amt);
    end
  endtask

  always @(posedge clk) begin : check_results
    fifo_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h valid %0d last %0d moved %0d level %0d",
                   out_if.out_byte, out_if.byte_valid, out_if.last, out_if.moved,
                   out_if.level);
      end else begin
        want = owed_results.pop_front();
        if (out_if.out_byte !== want.data || out_if.byte_valid !== want.has_byte ||
            out_if.last !== want.last || out_if.moved !== want.moved ||
            out_if.level !== want.level) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected byte %02h valid %0d last %0d moved %0d level %0d",
                     want.data, want.has_byte, want.last, want.moved, want.level);
            $display("          actual   byte %02h valid %0d last %0d moved %0d level %0d",
                     out_if.out_byte, out_if.byte_valid, out_if.last, out_if.moved,
                     out_if.level);
          end
        end
      end
      sink_gap = sink_idle ? $urandom_range(0, 3) : 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
    end
  end

  // The long receiver stall is counted here in clock cycles once a test asks for it.
  initial begin : sink_hold
    hold_left = 0;
    forever begin
      @(hold_go);
      hold_left = 300;
      while (hold_left > 0) begin
        @(posedge clk);
        hold_left--;
      end
    end
  end

  initial begin : drive_ready
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= rst_n && sink_gap == 0 && hold_left == 0;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.func        = brf_pkg::FN_WRITE;
    in_if.write_byte  = '0;
    in_if.amount      = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = brf_pkg::CAP_RESET;
    ring_cap          = brf_pkg::CAP_RESET;
    rd_ptr            = 0;
    wr_ptr            = 0;
    stored            = 0;
    items_sent        = 0;
    caps_used         = 0;
    src_idle          = 1'b1;
    sink_idle         = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_capacity_corners();
    test_stall_and_drain();
    test_random_traffic(9'd2, 45);
    test_random_traffic(9'd7, 45);
    test_random_traffic(9'd511, 45);
    test_random_traffic(9'd255, 45);
    test_random_traffic(9'($urandom_range(1, 256)), 45);
    test_random_traffic(9'd300, 45);
    test_random_traffic(9'd256, 45);

    park_input();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("testbench: %0d commands, %0d results checked over %0d capacity settings",
             items_sent, results_seen, caps_used);
    $display("testbench: writes, reads, peeks and line grabs incl. full, empty and wrapped lines");
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_ifs.sv
hw/rtl/brf_front.sv
hw/rtl/brf_cmdq.sv
hw/rtl/brf_back.sv
hw/rtl/byte_ring_fifo_with_line_grab.sv
hw/rtl/brf_checker.sv
test/testbench.sv
